// File: rtl/thw_pkg.sv
package thw_pkg;

  // Table size default
  localparam int TASK_SLOTS_DEF = 8;

  // Milliseconds per second for the timeout conversion
  localparam int MS_PER_S = 1000;

  // Command codes
  localparam logic [1:0] CMD_REGISTER  = 2'd0;
  localparam logic [1:0] CMD_HEARTBEAT = 2'd1;
  localparam logic [1:0] CMD_CHECK     = 2'd2;
  localparam logic [1:0] CMD_FEED      = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADARG   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_MON_EN  = 2'd0;
  localparam logic [1:0] REG_TPS     = 2'd1;
  localparam logic [1:0] REG_MIN_TMO = 2'd2;
  localparam logic [1:0] REG_MAX_TMO = 2'd3;

  // Register reset values
  localparam logic        MON_EN_RST  = 1'b1;
  localparam logic [13:0] TPS_RST     = 14'd1000;
  localparam logic [15:0] MIN_TMO_RST = 16'd100;
  localparam logic [15:0] MAX_TMO_RST = 16'd60000;

  typedef struct packed {
    logic        mon_en;
    logic [13:0] tps;
    logic [15:0] min_tmo;
    logic [15:0] max_tmo;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_en;
    logic apply;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip_scan;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: rtl/thw_regs.sv
module thw_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output thw_pkg::cfg_t cfg
);
  import thw_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mon_en  <= MON_EN_RST;
      cfg_r.tps     <= TPS_RST;
      cfg_r.min_tmo <= MIN_TMO_RST;
      cfg_r.max_tmo <= MAX_TMO_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MON_EN:  cfg_r.mon_en  <= pwdata[0];
        REG_TPS:     cfg_r.tps     <= pwdata[13:0];
        REG_MIN_TMO: cfg_r.min_tmo <= pwdata[15:0];
        REG_MAX_TMO: cfg_r.max_tmo <= pwdata[15:0];
        default:     cfg_r.mon_en  <= cfg_r.mon_en;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_MON_EN:  prdata = {31'd0, cfg_r.mon_en};
      REG_TPS:     prdata = {18'd0, cfg_r.tps};
      REG_MIN_TMO: prdata = {16'd0, cfg_r.min_tmo};
      REG_MAX_TMO: prdata = {16'd0, cfg_r.max_tmo};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/thw_ctrl.sv
module thw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  thw_pkg::dp_stat_t stat,
  output thw_pkg::dp_cmd_t  cmd
);
  import thw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_DRAIN,
    S_APPLY,
    S_OUTPUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.scan_en  = 1'b0;
    cmd.apply    = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        state_nxt = stat.skip_scan ? S_APPLY : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_OUTPUT;
      end
      S_OUTPUT: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_apply_then_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |=> (state_r == S_OUTPUT))
    else $error("apply not followed by output");
  a_capture_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_START))
    else $error("capture did not start a transaction");
  a_scan_then_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_en && stat.scan_last) |=> (state_r == S_DRAIN))
    else $error("scan end did not drain");
`endif

endmodule

// File: rtl/thw_dp.sv
module thw_dp #(
  parameter int TASK_SLOTS = thw_pkg::TASK_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  thw_pkg::dp_cmd_t  cmd,
  output thw_pkg::dp_stat_t stat,
  input  thw_pkg::cfg_t     cfg,
  input  logic [1:0]        in_cmd,
  input  logic [15:0]       in_task_key,
  input  logic [15:0]       in_timeout_ms,
  input  logic [31:0]       in_now_tick,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status_code,
  output logic [2:0]        out_slot_index,
  output logic [7:0]        out_late_mask,
  output logic [15:0]       out_last_late_key,
  output logic [3:0]        out_active_count,
  output logic [31:0]       out_feed_count,
  output logic              out_refresh_pulse
);
  import thw_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int PAD_W = (TASK_SLOTS > 8) ? TASK_SLOTS : 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  // Captured transaction
  logic [1:0]  cmd_r;
  logic [15:0] key_r;
  logic [15:0] tmo_r;
  logic [31:0] now_r;

  // Slot table
  logic [15:0] slot_key_r   [TASK_SLOTS];
  logic [15:0] slot_tmo_r   [TASK_SLOTS];
  logic [31:0] slot_stamp_r [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] used_r, used_nxt;
  logic [TASK_SLOTS-1:0] late_r, late_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0] feeds_r, feeds_nxt;
  logic [15:0] late_key_r, late_key_nxt;

  // Scan stage
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      s0_elap;
  logic             s1_vld_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_used_r;
  logic             s1_match_r;
  logic [15:0]      s1_key_r;
  logic [29:0]      s1_prod_r;
  logic [41:0]      s1_elap_r;
  logic             s1_late;

  // Scan results
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             tflag_r;

  // Command outcome
  logic [2:0]       status;
  logic [IDX_W-1:0] slot;
  logic             wr_new;
  logic             wr_hb;
  logic             feed;
  logic [2:0]       res_status_r;
  logic [IDX_W-1:0] res_slot_r;
  logic             res_pulse_r;

  logic             out_vld_r, out_vld_nxt;
  logic [PAD_W-1:0] late_pad;

  assign stat.skip_scan = (cmd_r == CMD_FEED) || ((cmd_r == CMD_CHECK) && !cfg.mon_en);
  assign stat.scan_last = (idx_r == LAST_IDX);
  assign stat.out_busy  = out_vld_r && out_stall;

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      key_r <= in_task_key;
      tmo_r <= in_timeout_ms;
      now_r <= in_now_tick;
    end
  end

  // Read one slot per cycle, form both products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.scan_en;
      if (cmd.capture) begin
        idx_r <= '0;
      end else if (cmd.scan_en) begin
        idx_r <= stat.scan_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  // Elapsed ticks wrap at 32 bits
  assign s0_elap = now_r - slot_stamp_r[idx_r];

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      s1_idx_r   <= idx_r;
      s1_used_r  <= used_r[idx_r];
      s1_match_r <= used_r[idx_r] && (slot_key_r[idx_r] == key_r);
      s1_key_r   <= slot_key_r[idx_r];
      s1_prod_r  <= 30'(slot_tmo_r[idx_r]) * 30'(cfg.tps);
      s1_elap_r  <= 42'(s0_elap) * 42'(MS_PER_S);
    end
  end

  // Late when floor(tmo*tps/1000) < elapsed, i.e. tmo*tps < elapsed*1000
  assign s1_late = s1_used_r && ({12'd0, s1_prod_r} < s1_elap_r);

  // Collect first match, first free slot and timeout flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
      tflag_r <= 1'b0;
    end else if (cmd.capture) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
      tflag_r <= 1'b0;
    end else if (s1_vld_r) begin
      if (s1_match_r && !found_r) begin
        found_r <= 1'b1;
      end
      if (!s1_used_r && !free_r) begin
        free_r <= 1'b1;
      end
      if (s1_late && (cmd_r == CMD_CHECK)) begin
        tflag_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_match_r && !found_r) begin
      found_idx_r <= s1_idx_r;
    end
    if (s1_vld_r && !s1_used_r && !free_r) begin
      free_idx_r <= s1_idx_r;
    end
  end

  // Decide the outcome of the command
  always_comb begin
    status = ST_OK;
    slot   = '0;
    wr_new = 1'b0;
    wr_hb  = 1'b0;
    feed   = 1'b0;
    unique case (cmd_r)
      CMD_REGISTER: begin
        if ((tmo_r < cfg.min_tmo) || (tmo_r > cfg.max_tmo) || (key_r == 16'd0) || found_r) begin
          status = ST_BADARG;
        end else if (!free_r) begin
          status = ST_FULL;
        end else begin
          wr_new = 1'b1;
          slot   = free_idx_r;
        end
      end
      CMD_HEARTBEAT: begin
        if (!found_r) begin
          status = ST_NOTFOUND;
        end else begin
          wr_hb = 1'b1;
          slot  = found_idx_r;
        end
      end
      CMD_CHECK: status = tflag_r ? ST_TIMEOUT : ST_OK;
      CMD_FEED:  feed = 1'b1;
      default:   status = ST_OK;
    endcase
  end

  // Update marks, counts and last late key
  always_comb begin
    used_nxt     = used_r;
    late_nxt     = late_r;
    count_nxt    = count_r;
    feeds_nxt    = feeds_r;
    late_key_nxt = late_key_r;
    if (s1_vld_r && s1_late && (cmd_r == CMD_CHECK)) begin
      late_nxt[s1_idx_r] = 1'b1;
      late_key_nxt       = s1_key_r;
    end
    if (cmd.apply) begin
      if (wr_new) begin
        used_nxt[free_idx_r] = 1'b1;
        late_nxt[free_idx_r] = 1'b0;
        count_nxt            = count_r + 1'b1;
      end
      if (wr_hb) begin
        late_nxt[found_idx_r] = 1'b0;
      end
      if (feed) begin
        feeds_nxt = feeds_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      late_r     <= '0;
      count_r    <= '0;
      feeds_r    <= '0;
      late_key_r <= '0;
    end else begin
      used_r     <= used_nxt;
      late_r     <= late_nxt;
      count_r    <= count_nxt;
      feeds_r    <= feeds_nxt;
      late_key_r <= late_key_nxt;
    end
  end

  // Write slot contents
  always_ff @(posedge clk) begin
    if (cmd.apply && wr_new) begin
      slot_key_r[free_idx_r]   <= key_r;
      slot_tmo_r[free_idx_r]   <= tmo_r;
      slot_stamp_r[free_idx_r] <= now_r;
    end else if (cmd.apply && wr_hb) begin
      slot_stamp_r[found_idx_r] <= now_r;
    end
  end

  // Hold the outcome for the result
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_status_r <= status;
      res_slot_r   <= slot;
      res_pulse_r  <= feed;
    end
  end

  // Result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  assign late_pad = PAD_W'(late_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_code   <= res_status_r;
      out_slot_index    <= 3'(res_slot_r);
      out_late_mask     <= late_pad[7:0];
      out_last_late_key <= late_key_r;
      out_active_count  <= 4'(count_r);
      out_feed_count    <= feeds_r;
      out_refresh_pulse <= res_pulse_r;
    end
  end

  assign out_valid = out_vld_r;

`ifndef NO_ASSERTIONS
  a_count_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(used_r)))
    else $error("active count differs from used slots");
  a_late_only_used: assert property (@(posedge clk) disable iff (!rst_n)
    (late_r & ~used_r) == '0)
    else $error("late mark on a free slot");
  a_pulse_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_refresh_pulse) |-> (out_status_code == ST_OK))
    else $error("refresh pulse with error status");
  a_new_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && wr_new) |-> !used_r[free_idx_r])
    else $error("registration into a used slot");
`endif

endmodule

// File: rtl/task_heartbeat_watchdog_top.sv
// Task heartbeat watchdog: table of task slots with register, heartbeat, check, feed.
// After accept, register, heartbeat and enabled check pass through start, a scan of every
// slot (one table slot read per cycle), drain, apply and output; feed and disabled check skip scan and drain.
// One transaction at a time: in_stall stays high until the result is loaded, which out_stall can hold off.
// Reset (rst_n low, synchronous): slots free, late marks, counts and last late key
// cleared, registers at their defaults; slot key, timeout and stamp left unset.
module task_heartbeat_watchdog_top #(
  parameter int TASK_SLOTS = thw_pkg::TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_task_key,
  input  logic [15:0] in_timeout_ms,
  input  logic [31:0] in_now_tick,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status_code,
  output logic [2:0]  out_slot_index,
  output logic [7:0]  out_late_mask,
  output logic [15:0] out_last_late_key,
  output logic [3:0]  out_active_count,
  output logic [31:0] out_feed_count,
  output logic        out_refresh_pulse,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import thw_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  thw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  thw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  thw_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .stat              (dp_stat),
    .cfg               (cfg),
    .in_cmd            (in_cmd),
    .in_task_key       (in_task_key),
    .in_timeout_ms     (in_timeout_ms),
    .in_now_tick       (in_now_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status_code   (out_status_code),
    .out_slot_index    (out_slot_index),
    .out_late_mask     (out_late_mask),
    .out_last_late_key (out_last_late_key),
    .out_active_count  (out_active_count),
    .out_feed_count    (out_feed_count),
    .out_refresh_pulse (out_refresh_pulse)
  );

endmodule

// File: test/thw_checker.sv
`timescale 1ns / 100ps

// Watch the command, result and register channels, predict every result
// from the accepted commands and compare it with what the block returns.
module thw_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_task_key,
  input  logic [15:0] in_timeout_ms,
  input  logic [31:0] in_now_tick,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status_code,
  input  logic [2:0]  out_slot_index,
  input  logic [7:0]  out_late_mask,
  input  logic [15:0] out_last_late_key,
  input  logic [3:0]  out_active_count,
  input  logic [31:0] out_feed_count,
  input  logic        out_refresh_pulse,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count,
  output int          late_count
);
  import thw_pkg::*;

  localparam int SLOTS = TASK_SLOTS_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [7:0]  late_mask;
    logic [15:0] late_key;
    logic [3:0]  active;
    logic [31:0] feeds;
    logic        pulse;
  } watch_result_t;

  watch_result_t awaited_results[$];

  // Shadow copy of the registers and the task table
  cfg_t             cfg_q;
  logic [15:0]      key_tab[SLOTS];
  logic [15:0]      tmo_tab[SLOTS];
  logic [31:0]      stamp_tab[SLOTS];
  logic [SLOTS-1:0] used_bits;
  logic [SLOTS-1:0] late_bits;
  logic [3:0]       used_total;
  logic [31:0]      feed_total;
  logic [15:0]      last_late;

  int mismatches = 0;
  int compared = 0;
  int timeouts_seen = 0;

  assign fail_count    = mismatches;
  assign checked_count = compared;
  assign late_count    = timeouts_seen;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Look up an active slot by key
  function automatic int lookup_slot(input logic [15:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (used_bits[i] && key_tab[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return the result it yields
  function automatic watch_result_t run_command(input logic [1:0] cmd, input logic [15:0] key,
                                                input logic [15:0] tmo, input logic [31:0] now);
    watch_result_t res;
    int            hit;
    logic [31:0]   elapsed;
    logic [63:0]   limit;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_REGISTER: begin
        hit = lookup_slot(key);
        if (tmo < cfg_q.min_tmo || tmo > cfg_q.max_tmo || key == 16'd0 || hit >= 0) begin
          res.status = ST_BADARG;
        end else begin
          // take the lowest free slot
          hit = -1;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used_bits[i]) hit = i;
          end
          if (hit < 0) begin
            res.status = ST_FULL;
          end else begin
            key_tab[hit]   = key;
            tmo_tab[hit]   = tmo;
            stamp_tab[hit] = now;
            used_bits[hit] = 1'b1;
            late_bits[hit] = 1'b0;
            used_total++;
            res.slot = hit[2:0];
          end
        end
      end
      CMD_HEARTBEAT: begin
        hit = lookup_slot(key);
        if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          stamp_tab[hit] = now;
          late_bits[hit] = 1'b0;
          res.slot = hit[2:0];
        end
      end
      CMD_CHECK: begin
        // scan low to high so the highest late slot names the last late key
        if (cfg_q.mon_en) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (used_bits[i]) begin
              elapsed = now - stamp_tab[i];
              limit = (64'(tmo_tab[i]) * 64'(cfg_q.tps)) / 64'(MS_PER_S);
              if (64'(elapsed) > limit) begin
                late_bits[i] = 1'b1;
                last_late = key_tab[i];
                res.status = ST_TIMEOUT;
              end
            end
          end
        end
      end
      CMD_FEED: begin
        feed_total++;
        res.pulse = 1'b1;
      end
    endcase
    res.late_mask = late_bits[7:0];
    res.late_key  = last_late;
    res.active    = used_total;
    res.feeds     = feed_total;
    return res;
  endfunction

  always @(posedge clk) begin
    watch_result_t want;
    if (!rst_n) begin
      cfg_q = '{MON_EN_RST, TPS_RST, MIN_TMO_RST, MAX_TMO_RST};
      used_bits  = '0;
      late_bits  = '0;
      used_total = '0;
      feed_total = '0;
      last_late  = '0;
      awaited_results.delete();
    end else begin
      // compare a returned transaction with the oldest prediction
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing expected", out_status_code, 0);
        end else begin
          want = awaited_results.pop_front();
          compared++;
          if (out_status_code == ST_TIMEOUT) timeouts_seen++;
          if (out_status_code !== want.status)
            report_mismatch("status_code", out_status_code, want.status);
          if (out_slot_index !== want.slot)
            report_mismatch("slot_index", out_slot_index, want.slot);
          if (out_late_mask !== want.late_mask)
            report_mismatch("late_mask", out_late_mask, want.late_mask);
          if (out_last_late_key !== want.late_key)
            report_mismatch("last_late_key", out_last_late_key, want.late_key);
          if (out_active_count !== want.active)
            report_mismatch("active_count", out_active_count, want.active);
          if (out_feed_count !== want.feeds)
            report_mismatch("feed_count", out_feed_count, want.feeds);
          if (out_refresh_pulse !== want.pulse)
            report_mismatch("refresh_pulse", out_refresh_pulse, want.pulse);
        end
      end
      // predict the result of an accepted command
      if (in_valid && !in_stall) begin
        awaited_results.push_back(run_command(in_cmd, in_task_key, in_timeout_ms, in_now_tick));
      end
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MON_EN:  cfg_q.mon_en  = pwdata[0];
          REG_TPS:     cfg_q.tps     = pwdata[13:0];
          REG_MIN_TMO: cfg_q.min_tmo = pwdata[15:0];
          REG_MAX_TMO: cfg_q.max_tmo = pwdata[15:0];
        endcase
      end
    end
    pending_count <= awaited_results.size();
  end

endmodule

// File: test/task_heartbeat_watchdog_top_tb.sv
`timescale 1ns / 100ps

module task_heartbeat_watchdog_top_tb;
  import thw_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 54;

  localparam logic [15:0] KEY_POOL [10] = '{16'h0001, 16'hFFFF, 16'h8000, 16'h00FF, 16'h1234,
                                            16'hA5A5, 16'h5A5A, 16'h7FFF, 16'h0100, 16'hFF00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_FEED;
  logic [15:0] in_task_key = '0;
  logic [15:0] in_timeout_ms = '0;
  logic [31:0] in_now_tick = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status_code;
  logic [2:0]  out_slot_index;
  logic [7:0]  out_late_mask;
  logic [15:0] out_last_late_key;
  logic [3:0]  out_active_count;
  logic [31:0] out_feed_count;
  logic        out_refresh_pulse;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_count;
  int checked_count;
  int late_count;

  int          items_sent = 0;
  int          stuck_cycles = 0;
  bit          quiet_run = 1'b0;
  bit          hold_request = 1'b0;
  logic [15:0] cur_min = MIN_TMO_RST;
  logic [15:0] cur_max = MAX_TMO_RST;
  logic [31:0] sim_tick = 32'hFFFF_FF00;

  always #5 clk = ~clk;

  task_heartbeat_watchdog_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_task_key       (in_task_key),
    .in_timeout_ms     (in_timeout_ms),
    .in_now_tick       (in_now_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status_code   (out_status_code),
    .out_slot_index    (out_slot_index),
    .out_late_mask     (out_late_mask),
    .out_last_late_key (out_last_late_key),
    .out_active_count  (out_active_count),
    .out_feed_count    (out_feed_count),
    .out_refresh_pulse (out_refresh_pulse),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  thw_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_task_key       (in_task_key),
    .in_timeout_ms     (in_timeout_ms),
    .in_now_tick       (in_now_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status_code   (out_status_code),
    .out_slot_index    (out_slot_index),
    .out_late_mask     (out_late_mask),
    .out_last_late_key (out_last_late_key),
    .out_active_count  (out_active_count),
    .out_feed_count    (out_feed_count),
    .out_refresh_pulse (out_refresh_pulse),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .fail_count        (fail_count),
    .pending_count     (pending_count),
    .checked_count     (checked_count),
    .late_count        (late_count)
  );

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STUCK_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int unsigned roll;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet_run) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else if (roll < 96) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_run || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return KEY_POOL[$urandom_range(0, 9)];
    if (roll < 95) return 16'($urandom_range(0, 65535));
    return 16'd0;
  endfunction

  // Mostly a timeout the current limits accept, sometimes any value
  function automatic logic [15:0] pick_timeout();
    int hi;
    if (cur_min <= cur_max && $urandom_range(0, 9) < 8) begin
      hi = (int'(cur_max) - int'(cur_min) > 3000) ? int'(cur_min) + 3000 : int'(cur_max);
      return 16'($urandom_range(int'(cur_min), hi));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offer one transaction and hold it until accepted, then idle at random
  task automatic send_command(input logic [1:0] cmd, input logic [15:0] key,
                              input logic [15:0] tmo, input logic [31:0] now);
    int gap;
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_task_key   <= key;
    in_timeout_ms <= tmo;
    in_now_tick   <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_command();
    int unsigned roll;
    logic [1:0]  cmd;
    logic [31:0] now;
    roll = $urandom_range(0, 99);
    if (roll < 80) sim_tick = sim_tick + $urandom_range(0, 300);
    else if (roll < 97) sim_tick = sim_tick + $urandom_range(300, 80000);
    else sim_tick = sim_tick + $urandom();
    now = ($urandom_range(0, 99) < 3) ? $urandom() : sim_tick;
    roll = $urandom_range(0, 99);
    if (roll < 22) cmd = CMD_REGISTER;
    else if (roll < 55) cmd = CMD_HEARTBEAT;
    else if (roll < 85) cmd = CMD_CHECK;
    else cmd = CMD_FEED;
    send_command(cmd, pick_key(), pick_timeout(), now);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic mon, input logic [13:0] tps, input logic [15:0] lo,
                           input logic [15:0] hi, input int count, input bit quiet,
                           input bit hold);
    drain_block();
    write_register(REG_MON_EN, 32'(mon));
    write_register(REG_TPS, 32'(tps));
    write_register(REG_MIN_TMO, 32'(lo));
    write_register(REG_MAX_TMO, 32'(hi));
    cur_min = lo;
    cur_max = hi;
    quiet_run = quiet;
    if (hold) hold_request = 1'b1;
    repeat (count) send_random_command();
    quiet_run = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: argument checks, wrap of the tick, late marks and their clearing
    send_command(CMD_FEED, 16'h0000, 16'h0000, 32'h0000_0000);
    send_command(CMD_REGISTER, 16'h0001, 16'd100, sim_tick);
    send_command(CMD_REGISTER, 16'hFFFF, 16'd60000, sim_tick);
    send_command(CMD_REGISTER, 16'h0000, 16'd500, sim_tick);
    send_command(CMD_REGISTER, 16'h0005, 16'd99, sim_tick);
    send_command(CMD_REGISTER, 16'h0005, 16'd60001, sim_tick);
    send_command(CMD_REGISTER, 16'h0001, 16'd200, sim_tick);
    send_command(CMD_REGISTER, 16'h0005, 16'd200, sim_tick);
    send_command(CMD_REGISTER, 16'h0009, 16'd0, sim_tick);
    send_command(CMD_HEARTBEAT, 16'h0000, 16'hFFFF, sim_tick);
    send_command(CMD_HEARTBEAT, 16'h0007, 16'h0000, sim_tick);
    send_command(CMD_CHECK, 16'h0000, 16'h0000, sim_tick + 32'd50);
    send_command(CMD_CHECK, 16'h0000, 16'h0000, sim_tick + 32'd150);
    send_command(CMD_CHECK, 16'h0000, 16'h0000, sim_tick + 32'd150);
    send_command(CMD_HEARTBEAT, 16'h0001, 16'h0000, sim_tick + 32'd160);
    send_command(CMD_CHECK, 16'hFFFF, 16'hFFFF, sim_tick + 32'd300);
    send_command(CMD_FEED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CMD_REGISTER, 16'h8000, 16'd1000, sim_tick + 32'd300);
    send_command(CMD_HEARTBEAT, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send_command(CMD_CHECK, 16'h0000, 16'h0000, 32'h0000_0000);
    sim_tick = sim_tick + 32'd300;

    // Random phases, each under its own register setting
    run_phase(1'b1, 14'd1000, 16'd100, 16'd60000, PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(1'b0, 14'd1000, 16'd1, 16'd65535, PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(1'b1, 14'd0, 16'd1, 16'd65535, PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(1'b1, 14'd10000, 16'd1, 16'd65535, PHASE_ITEMS, 1'b1, 1'b0);
    run_phase(1'b1, 14'd1, 16'd65535, 16'd65535, PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(1'b1, 14'd16383, 16'd50, 16'd40, PHASE_ITEMS, 1'b0, 1'b0);
    run_phase(1'b1, 14'd1000, 16'd1, 16'd65535, PHASE_ITEMS, 1'b0, 1'b1);
    run_phase(1'b1, 14'd37, 16'd10, 16'd3000, PHASE_ITEMS, 1'b0, 1'b0);

    // Fresh keys beyond the table size run into a full table
    run_phase(1'b1, 14'd1000, 16'd1, 16'd65535, 0, 1'b0, 1'b0);
    for (int i = 0; i < 9; i++) begin
      send_command(CMD_REGISTER, 16'h0F00 + 16'(i), 16'd500, sim_tick);
    end

    drain_block();
    repeat (20) @(posedge clk);
    $display("Sent %0d commands under %0d register settings, one with a long result hold-off.",
             items_sent, NUM_PHASES);
    $display("Checked %0d results, %0d of them reporting a late task.", checked_count,
             late_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/thw_pkg.sv
rtl/thw_regs.sv
rtl/thw_ctrl.sv
rtl/thw_dp.sv
rtl/task_heartbeat_watchdog_top.sv
test/thw_checker.sv
test/task_heartbeat_watchdog_top_tb.sv
